// File: rtl/ifp_pkg.sv
// Shared types, codes and the precedence function for the infix to postfix converter.
// No dependencies; every other file in rtl/ refers to this package by scoped names.

package ifp_pkg;

   // Token kinds on the request side.
   localparam logic [1:0] CMD_OPERAND  = 2'd0;
   localparam logic [1:0] CMD_OPERATOR = 2'd1;
   localparam logic [1:0] CMD_END      = 2'd2;

   // Symbol codes shared by the request and the response.
   localparam logic [2:0] SYM_PLUS   = 3'd0;
   localparam logic [2:0] SYM_MINUS  = 3'd1;
   localparam logic [2:0] SYM_TIMES  = 3'd2;
   localparam logic [2:0] SYM_DIVIDE = 3'd3;
   localparam logic [2:0] SYM_POWER  = 3'd4;
   localparam logic [2:0] SYM_OPEN   = 3'd5;
   localparam logic [2:0] SYM_CLOSE  = 3'd6;

   // Result kinds on the response side.
   localparam logic [1:0] KIND_OPERAND  = 2'd0;
   localparam logic [1:0] KIND_OPERATOR = 2'd1;
   localparam logic [1:0] KIND_MISMATCH = 2'd2;
   localparam logic [1:0] KIND_OVERFLOW = 2'd3;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [63:0] operand_bits;
      logic [2:0]  symbol_code;
   } req_type;

   typedef struct packed {
      logic [1:0]  token_kind;
      logic [63:0] out_value;
      logic [2:0]  out_symbol;
      logic        last;
   } rsp_type;

   // Control from the sequencer to the operator stack.
   typedef struct packed {
      logic       push;
      logic       pop;
      logic       clear;
      logic       read;
      logic [2:0] sym;
   } stack_ctl_type;

   // Operator precedence; parentheses and unused codes rank lowest.
   function automatic logic [1:0] prec_of(input logic [2:0] sym);
      logic [1:0] prec;
      case (sym)
         SYM_PLUS, SYM_MINUS:   prec = 2'd1;
         SYM_TIMES, SYM_DIVIDE: prec = 2'd2;
         SYM_POWER:             prec = 2'd3;
         default:               prec = 2'd0;
      endcase
      return prec;
   endfunction

endpackage

// File: rtl/ifp_stack.sv
// Operator stack: a single-port memory with a registered top read and a fill count.
// Depends on ifp_pkg for the stack control struct.

module ifp_stack #(
   parameter int STACK_DEPTH = 32,
   localparam int CNT_W = $clog2(STACK_DEPTH + 1),
   localparam int IDX_W = $clog2(STACK_DEPTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ifp_pkg::stack_ctl_type stk_ctl,
   output logic [CNT_W-1:0]      stk_count,
   output logic [2:0]            stk_top
);

   logic [2:0]       stack_mem [STACK_DEPTH];
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] top_addr;
   logic [2:0]       top_ff;

   assign top_addr = count_ff - CNT_W'(1);

   // Push writes above the top; a read fetches the current top into a register.
   always_ff @(posedge clock) begin
      if (stk_ctl.push) begin
         stack_mem[count_ff[IDX_W-1:0]] <= stk_ctl.sym;
      end
      if (stk_ctl.read) begin
         top_ff <= stack_mem[top_addr[IDX_W-1:0]];
      end
   end

   // Fill count; entries at or above it are never read.
   always_comb begin
      count_in = count_ff;
      if (stk_ctl.clear) begin
         count_in = '0;
      end else if (stk_ctl.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (stk_ctl.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign stk_count = count_ff;
   assign stk_top   = top_ff;

endmodule

// File: rtl/infix_to_postfix_converter_top.sv
// Top level of the shunting-yard infix to postfix converter: sequencer and result staging.
// Depends on ifp_pkg and instantiates ifp_stack.
//
//   channel   direction  handshake               payload
//   req_      in         req_valid / req_stall   ifp_pkg::req_type (one token)
//   rsp_      out        rsp_valid / rsp_stall   ifp_pkg::rsp_type (one postfix token)
//
// Every token passes the decide and finish states after its transfer; an operator or an
// open paren also passes the push state, and a close paren or an end does not.
// Each stack entry examined adds a read state (address) and an evaluate state (registered
// memory read), and a mismatch result adds a mismatch state, as the memory has one port.
// Reset is synchronous and clears the stack count, the sequencer and the result valids.
// A stalled response holds the sequencer only when a new result has nowhere to go.

module infix_to_postfix_converter_top #(
   parameter int STACK_DEPTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ifp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ifp_pkg::rsp_type rsp_data
);

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DECIDE   = 3'd1;
   localparam logic [2:0] S_READ     = 3'd2;
   localparam logic [2:0] S_EVAL     = 3'd3;
   localparam logic [2:0] S_PUSH     = 3'd4;
   localparam logic [2:0] S_MISMATCH = 3'd5;
   localparam logic [2:0] S_FINISH   = 3'd6;

   logic [2:0]             state_ff;
   logic [2:0]             state_in;
   ifp_pkg::req_type       item_ff;
   ifp_pkg::rsp_type       pend_ff;
   logic                   pend_valid_ff;
   logic                   pend_valid_in;
   ifp_pkg::rsp_type       rsp_data_ff;
   ifp_pkg::rsp_type       rsp_data_in;
   logic                   rsp_valid_ff;
   ifp_pkg::stack_ctl_type stk_ctl;
   logic [CNT_W-1:0]       stk_count;
   logic [2:0]             stk_top;
   logic                   out_free;
   logic                   can_gen;
   logic                   gen;
   logic                   flush;
   ifp_pkg::rsp_type       gen_rsp;
   logic                   stk_empty;
   logic                   stk_full;
   logic                   stk_one;
   logic                   pop_due;
   logic [1:0]             item_prec;
   logic [1:0]             top_prec;

   ifp_stack #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_stack (
      .clock    (clock),
      .reset    (reset),
      .stk_ctl  (stk_ctl),
      .stk_count(stk_count),
      .stk_top  (stk_top)
   );

   assign stk_empty = (stk_count == '0);
   assign stk_full  = (stk_count == CNT_W'(STACK_DEPTH));
   assign stk_one   = (stk_count == CNT_W'(1));

   // A result is held back in a pending register so the final one of an item can be marked.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign can_gen  = !pend_valid_ff || out_free;

   // Left-associative operators pop equal precedence; power does not.
   assign item_prec = ifp_pkg::prec_of(item_ff.symbol_code);
   assign top_prec  = ifp_pkg::prec_of(stk_top);
   assign pop_due   = (top_prec > item_prec) ||
                      ((top_prec == item_prec) && (item_ff.symbol_code != ifp_pkg::SYM_POWER));

   // Sequencer: at most one stack action and at most one result per cycle.
   always_comb begin
      state_in   = state_ff;
      gen        = 1'b0;
      flush      = 1'b0;
      gen_rsp    = '0;
      stk_ctl    = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            case (item_ff.cmd)
               ifp_pkg::CMD_OPERAND: begin
                  if (can_gen) begin
                     gen                = 1'b1;
                     gen_rsp.token_kind = ifp_pkg::KIND_OPERAND;
                     gen_rsp.out_value  = item_ff.operand_bits;
                     state_in           = S_FINISH;
                  end
               end
               ifp_pkg::CMD_OPERATOR: begin
                  if (item_ff.symbol_code == ifp_pkg::SYM_OPEN) begin
                     state_in = S_PUSH;
                  end else if (item_ff.symbol_code == ifp_pkg::SYM_CLOSE) begin
                     state_in = stk_empty ? S_MISMATCH : S_READ;
                  end else if (item_ff.symbol_code <= ifp_pkg::SYM_POWER) begin
                     state_in = stk_empty ? S_PUSH : S_READ;
                  end else begin
                     state_in = S_FINISH;
                  end
               end
               ifp_pkg::CMD_END: begin
                  state_in = stk_empty ? S_FINISH : S_READ;
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_READ: begin
            stk_ctl.read = 1'b1;
            state_in     = S_EVAL;
         end
         S_EVAL: begin
            gen_rsp.token_kind = ifp_pkg::KIND_OPERATOR;
            gen_rsp.out_symbol = stk_top;
            if (item_ff.cmd == ifp_pkg::CMD_END) begin
               if (can_gen) begin
                  gen         = 1'b1;
                  stk_ctl.pop = 1'b1;
                  state_in    = stk_one ? S_FINISH : S_READ;
               end
            end else if (item_ff.symbol_code == ifp_pkg::SYM_CLOSE) begin
               if (stk_top == ifp_pkg::SYM_OPEN) begin
                  stk_ctl.pop = 1'b1;
                  state_in    = S_FINISH;
               end else if (can_gen) begin
                  gen         = 1'b1;
                  stk_ctl.pop = 1'b1;
                  state_in    = stk_one ? S_MISMATCH : S_READ;
               end
            end else if (pop_due) begin
               if (can_gen) begin
                  gen         = 1'b1;
                  stk_ctl.pop = 1'b1;
                  state_in    = stk_one ? S_PUSH : S_READ;
               end
            end else begin
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            if (stk_full) begin
               if (can_gen) begin
                  gen                = 1'b1;
                  gen_rsp.token_kind = ifp_pkg::KIND_OVERFLOW;
                  stk_ctl.clear      = 1'b1;
                  state_in           = S_FINISH;
               end
            end else begin
               stk_ctl.push = 1'b1;
               stk_ctl.sym  = item_ff.symbol_code;
               state_in     = S_FINISH;
            end
         end
         S_MISMATCH: begin
            if (can_gen) begin
               gen                = 1'b1;
               gen_rsp.token_kind = ifp_pkg::KIND_MISMATCH;
               state_in           = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               flush    = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (gen) begin
         pend_valid_in = 1'b1;
      end else if (flush) begin
         pend_valid_in = 1'b0;
      end
   end

   // The held-back result goes out, marked last when the item is done.
   always_comb begin
      rsp_data_in      = pend_ff;
      rsp_data_in.last = flush;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         if ((gen && pend_valid_ff) || flush) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload: the accepted token, the held-back result and the output register.
   always_ff @(posedge clock) begin
      if ((state_ff == S_IDLE) && req_valid) begin
         item_ff <= req_data;
      end
      if (gen) begin
         pend_ff <= gen_rsp;
      end
      if ((gen && pend_valid_ff) || flush) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The stack never holds more than its depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      stk_count <= CNT_W'(STACK_DEPTH))
      else $error("operator stack count beyond depth");

   // Nothing is held back while waiting for a new token.
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_valid_ff)
      else $error("result left pending at idle");

   // A result never overwrites an output that is still stalled.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !((gen && pend_valid_ff) || flush))
      else $error("stalled result overwritten");

   // Stack count moves by at most one unless cleared.
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !stk_ctl.clear |=> (stk_count == $past(stk_count)) ||
                         (stk_count == $past(stk_count) + CNT_W'(1)) ||
                         (stk_count == $past(stk_count) - CNT_W'(1)))
      else $error("stack count jumped");

endmodule
